// File: design/assert_macros.svh
// Assertion macros used by the checker file (thc_checker).
// No dependencies; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/thc_pkg.sv
// Package for the temperature/humidity compensation block: widths, codes,
// controller states, datapath commands. No dependencies.
package thc_pkg;

	localparam int RAW_W      = 20;
	localparam int VAL_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] HUM_X_OFFSET = 32'd76800;
	localparam logic [31:0] HUM_UPPER    = 32'd419430400;
	localparam logic [31:0] RND_TEMP     = 32'd128;
	localparam logic [31:0] RND_P        = 32'd16384;
	localparam logic [31:0] RND_Q        = 32'd8192;
	localparam logic [31:0] OFS_Q2       = 32'd32768;
	localparam logic [31:0] OFS_Q        = 32'd2097152;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_T1, CFG_T2, CFG_T3, CFG_H1, CFG_H2, CFG_H3, CFG_H45, CFG_H6
	} cfg_reg_t;

	typedef enum logic {
		KIND_TEMP = 1'b0,
		KIND_HUM  = 1'b1
	} kind_t;

	// One controller state per datapath step.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_H9
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_T0, OP_T1, OP_T2, OP_T3, OP_T4,
		OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_H6, OP_H7, OP_H8, OP_H9
	} op_t;

	typedef struct packed {
		logic capture;   // latch incoming word
		op_t  op;        // datapath step
		logic out_load;  // load output register
	} cmd_t;

endpackage

// File: design/thc_if.sv
// Handshake channels of the compensation block: sample in, result out.
// Depends on thc_pkg.
interface thc_in_if;
	import thc_pkg::*;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [RAW_W-1:0] raw_value;

	modport source (output valid, output req_type, output raw_value, input ready);
	modport sink   (input valid, input req_type, input raw_value, output ready);
endinterface

interface thc_out_if;
	import thc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    result_kind;
	logic signed [VAL_W-1:0] result_value;

	modport source (output valid, output result_kind, output result_value, input ready);
	modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

// File: design/temp_humidity_compensation.sv
// Top level of the temperature/humidity calibration compensation block.
// Depends on thc_pkg, thc_if (thc_in_if, thc_out_if), thc_ctrl, thc_datapath.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-------------------------------------
//  sample   | in  | valid / ready  | req_type, raw_value[19:0]
//  result   | out | valid / ready  | result_kind, result_value[31:0] signed
//  cfg      | in  | cfg_we         | cfg_index[2:0], cfg_wdata[31:0]
//
// A temperature word steps through ST_T0..ST_T4 and a humidity word through
// ST_H0..ST_H9, one product per cycle through the single shared 32x32
// multiplier (3 products for temperature, 8 for humidity) plus setup and
// finishing steps; the next word is taken back in ST_IDLE.
// Reset clears the coefficients and the stored fine temperature to zero.
// A finished word waits in the output register; a new sample is taken
// meanwhile, and only its last step stalls if the result is still unread.
module temp_humidity_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	thc_in_if.sink                         sample,
	thc_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import thc_pkg::*;

	cmd_t cmd;
	logic in_ready, out_valid;
	logic out_kind;
	logic signed [VAL_W-1:0] out_value;

	// sequencer: one step per cycle (the last step waits for a free output register), owns both handshake flags
	thc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample.valid),
		.in_req_type (sample.req_type),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (result.ready),
		.cmd         (cmd)
	);

	// arithmetic, coefficients, fine temperature, output word
	thc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_req_type  (sample.req_type),
		.in_raw_value (sample.raw_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.out_kind     (out_kind),
		.out_value    (out_value)
	);

	assign sample.ready        = in_ready;
	assign result.valid        = out_valid;
	assign result.result_kind  = out_kind;
	assign result.result_value = out_value;

endmodule

// File: design/thc_datapath.sv
// Datapath: calibration registers, fine temperature, one shared 32x32
// multiplier with registered product, output word register. Uses thc_pkg.
module thc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  thc_pkg::cmd_t                  cmd,
	input  logic                           in_req_type,
	input  logic [thc_pkg::RAW_W-1:0]      in_raw_value,
	input  logic                           cfg_we,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           out_kind,
	output logic signed [thc_pkg::VAL_W-1:0] out_value
);
	import thc_pkg::*;

	logic [15:0] cal_t1_q, cal_t2_q, cal_t3_q, cal_h2_q;
	logic [7:0]  cal_h1_q, cal_h3_q, cal_h6_q;
	logic [31:0] cal_h45_q;
	logic [31:0] fine_q;

	logic [RAW_W-1:0] raw_q;
	logic             kind_q;
	logic [31:0]      prod_q, acc_q, q1_q, x_q, x2_q;
	logic             res_kind_q;
	logic [31:0]      res_value_q;

	// sign/zero extended coefficients
	logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
	logic [31:0] mul_a, mul_b, mul_p;
	logic        prod_ld, acc_ld, q1_ld, x_ld, x2_ld, fine_ld;
	logic [31:0] acc_d, q1_d, fine_d;
	logic [31:0] temp_a, temp_d, temp_5, s_val, hum_x, hum_c, res_d;

	assign t1 = {16'b0, cal_t1_q};
	assign t2 = {{16{cal_t2_q[15]}}, cal_t2_q};
	assign t3 = {{16{cal_t3_q[15]}}, cal_t3_q};
	assign h1 = {24'b0, cal_h1_q};
	assign h2 = {{16{cal_h2_q[15]}}, cal_h2_q};
	assign h3 = {24'b0, cal_h3_q};
	assign h4 = {{16{cal_h45_q[15]}}, cal_h45_q[15:0]};
	assign h5 = {{16{cal_h45_q[31]}}, cal_h45_q[31:16]};
	assign h6 = {{24{cal_h6_q[7]}}, cal_h6_q};

	assign temp_a = {15'b0, raw_q[19:3]} - {15'b0, cal_t1_q, 1'b0};
	assign temp_d = {16'b0, raw_q[19:4]} - t1;
	assign s_val  = 32'($signed(prod_q) >>> 15);

	// low 32 bits only: all sums and products wrap
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		prod_ld = 1'b0;
		acc_ld  = 1'b0;
		q1_ld   = 1'b0;
		x_ld    = 1'b0;
		x2_ld   = 1'b0;
		fine_ld = 1'b0;
		acc_d   = 32'($signed(prod_q) >>> 11);
		q1_d    = 32'($signed(prod_q) >>> 10);
		fine_d  = acc_q + 32'($signed(prod_q) >>> 14);
		case (cmd.op)
			OP_T0: begin
				mul_a = temp_a; mul_b = t2; prod_ld = 1'b1;
			end
			OP_T1: begin
				acc_ld = 1'b1;
				mul_a = temp_d; mul_b = temp_d; prod_ld = 1'b1;
			end
			OP_T2: begin
				mul_a = 32'($signed(prod_q) >>> 12); mul_b = t3; prod_ld = 1'b1;
			end
			OP_T3: begin
				fine_ld = 1'b1;
			end
			OP_H0: begin
				x_ld = 1'b1;
			end
			OP_H1: begin
				mul_a = x_q; mul_b = h5; prod_ld = 1'b1;
			end
			OP_H2: begin
				acc_ld = 1'b1;
				acc_d  = 32'($signed({2'b0, raw_q[15:0], 14'b0} - {h4[11:0], 20'b0}
					- prod_q + RND_P) >>> 15);
				mul_a = x_q; mul_b = h6; prod_ld = 1'b1;
			end
			OP_H3: begin
				q1_ld = 1'b1;
				mul_a = x_q; mul_b = h3; prod_ld = 1'b1;
			end
			OP_H4: begin
				mul_a = q1_q;
				mul_b = 32'($signed(prod_q) >>> 11) + OFS_Q2;
				prod_ld = 1'b1;
			end
			OP_H5: begin
				mul_a = 32'($signed(prod_q) >>> 10) + OFS_Q;
				mul_b = h2;
				prod_ld = 1'b1;
			end
			OP_H6: begin
				mul_a = acc_q;
				mul_b = 32'($signed(prod_q + RND_Q) >>> 14);
				prod_ld = 1'b1;
			end
			OP_H7: begin
				x2_ld = 1'b1;
				mul_a = s_val; mul_b = s_val; prod_ld = 1'b1;
			end
			OP_H8: begin
				mul_a = 32'($signed(prod_q) >>> 7); mul_b = h1; prod_ld = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// temperature: (fine * 5 + 128) >>> 8
	assign temp_5 = {fine_q[29:0], 2'b0} + fine_q + RND_TEMP;

	// humidity: clamp to 0..HUM_UPPER, then >> 12
	assign hum_x = x2_q - 32'($signed(prod_q) >>> 4);
	always_comb begin
		if (hum_x[31]) begin
			hum_c = '0;
		end else if (hum_x > HUM_UPPER) begin
			hum_c = HUM_UPPER;
		end else begin
			hum_c = hum_x;
		end
	end

	assign res_d = (kind_q == KIND_HUM) ? {12'b0, hum_c[31:12]}
		: 32'($signed(temp_5) >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q  <= '0;
			cal_t2_q  <= '0;
			cal_t3_q  <= '0;
			cal_h1_q  <= '0;
			cal_h2_q  <= '0;
			cal_h3_q  <= '0;
			cal_h45_q <= '0;
			cal_h6_q  <= '0;
			fine_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_T1:  cal_t1_q  <= cfg_wdata[15:0];
					CFG_T2:  cal_t2_q  <= cfg_wdata[15:0];
					CFG_T3:  cal_t3_q  <= cfg_wdata[15:0];
					CFG_H1:  cal_h1_q  <= cfg_wdata[7:0];
					CFG_H2:  cal_h2_q  <= cfg_wdata[15:0];
					CFG_H3:  cal_h3_q  <= cfg_wdata[7:0];
					CFG_H45: cal_h45_q <= cfg_wdata;
					CFG_H6:  cal_h6_q  <= cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			if (fine_ld) begin
				fine_q <= fine_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q  <= in_raw_value;
			kind_q <= in_req_type;
		end
		if (prod_ld) prod_q <= mul_p;
		if (acc_ld)  acc_q  <= acc_d;
		if (q1_ld)   q1_q   <= q1_d;
		if (x_ld)    x_q    <= fine_q - HUM_X_OFFSET;
		if (x2_ld)   x2_q   <= prod_q;
		if (cmd.out_load) begin
			res_kind_q  <= kind_q;
			res_value_q <= res_d;
		end
	end

	assign out_kind  = res_kind_q;
	assign out_value = $signed(res_value_q);

endmodule

// File: design/thc_ctrl.sv
// Controller: steps the datapath one operation per cycle (the last one waits
// for a free output register) and owns the input ready and output valid flags. Uses thc_pkg.
module thc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_req_type,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output thc_pkg::cmd_t cmd
);
	import thc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept, out_free, finish;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_T4) || (state_q == ST_H9);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_req_type == KIND_HUM) ? ST_H0 : ST_T0;
				end
			end
			ST_T0: state_d = ST_T1;
			ST_T1: state_d = ST_T2;
			ST_T2: state_d = ST_T3;
			ST_T3: state_d = ST_T4;
			ST_T4: if (out_free) state_d = ST_IDLE;
			ST_H0: state_d = ST_H1;
			ST_H1: state_d = ST_H2;
			ST_H2: state_d = ST_H3;
			ST_H3: state_d = ST_H4;
			ST_H4: state_d = ST_H5;
			ST_H5: state_d = ST_H6;
			ST_H6: state_d = ST_H7;
			ST_H7: state_d = ST_H8;
			ST_H8: state_d = ST_H9;
			ST_H9: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.capture  = accept;
		cmd.out_load = finish && out_free;
		case (state_q)
			ST_T0:   cmd.op = OP_T0;
			ST_T1:   cmd.op = OP_T1;
			ST_T2:   cmd.op = OP_T2;
			ST_T3:   cmd.op = OP_T3;
			ST_T4:   cmd.op = OP_T4;
			ST_H0:   cmd.op = OP_H0;
			ST_H1:   cmd.op = OP_H1;
			ST_H2:   cmd.op = OP_H2;
			ST_H3:   cmd.op = OP_H3;
			ST_H4:   cmd.op = OP_H4;
			ST_H5:   cmd.op = OP_H5;
			ST_H6:   cmd.op = OP_H6;
			ST_H7:   cmd.op = OP_H7;
			ST_H8:   cmd.op = OP_H8;
			ST_H9:   cmd.op = OP_H9;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/thc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
// Depends on assert_macros.svh and temp_humidity_compensation.
`include "assert_macros.svh"

module thc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic [31:0] out_value
);

	// a held result keeps its word
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_value) && $stable(out_kind), "result word changed while stalled")

	// one word in flight: busy right after an accept
	`ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "second word taken during computation")

	// humidity is clamped to 0..100 percent in Q22.10
	`ASSERT_IMPLY(a_hum_range, clk, arst_n, out_valid && out_kind, !out_value[31] && (out_value <= 32'd102400), "humidity out of range")

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.result_kind),
	.out_value (result.result_value)
);

// File: tb/temp_humidity_compensation_test.sv
// Self-checking bench for temp_humidity_compensation: directed table, then random words.
// A local predictor checks every result. Depends on thc_pkg, thc_if and the block's RTL.
module temp_humidity_compensation_test;
	import thc_pkg::*;

	localparam int CFG_COUNT    = 8;
	localparam int RANDOM_WORDS = 850;
	localparam int FINAL_WORDS  = 90;      // tail of the run, no idling on either side
	localparam int DRAIN_CYCLES = 24;      // slowest word is a humidity word
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;

	// How a calibration set is picked before a phase.
	typedef enum logic [2:0] {
		CAL_KEEP,      // no write, coefficients stay as they are
		CAL_TYPICAL,   // datasheet-like sample part
		CAL_MAX,       // every coefficient at its top
		CAL_MIN,       // every coefficient at its bottom
		CAL_NEAR,      // random, close to a real part
		CAL_RANDOM     // full 32-bit garbage on every register
	} cal_style_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
	} reading_t;

	// typed = 1: value is the expected result, read straight off the spec
	typedef struct packed {
		cal_style_t  cal;
		kind_t       kind;
		logic [19:0] raw;
		logic        typed;
		logic [31:0] value;
	} stim_row_t;

	stim_row_t directed_rows [23] = '{
		// reset coefficients: everything compensates to zero
		'{CAL_KEEP,    KIND_HUM,  20'h12345, 1'b1, 32'd0},   // humidity before any temp
		'{CAL_KEEP,    KIND_TEMP, 20'h00000, 1'b1, 32'd0},
		'{CAL_KEEP,    KIND_TEMP, 20'hFFFFF, 1'b1, 32'd0},
		'{CAL_KEEP,    KIND_HUM,  20'h0FFFF, 1'b1, 32'd0},
		'{CAL_KEEP,    KIND_TEMP, 20'd519888, 1'b1, 32'd0},
		// sample part, fine temperature still zero on the first humidity word
		'{CAL_TYPICAL, KIND_HUM,  20'h06A5C, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_TEMP, 20'd519888, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_HUM,  20'h06A5C, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_HUM,  20'hF6A5C, 1'b0, 32'd0},   // upper nibble must be dropped
		'{CAL_TYPICAL, KIND_HUM,  20'h00000, 1'b0, 32'd0},   // clamps low
		'{CAL_TYPICAL, KIND_HUM,  20'h0FFFF, 1'b0, 32'd0},   // clamps high
		'{CAL_TYPICAL, KIND_TEMP, 20'h00000, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_TEMP, 20'hFFFFF, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_TEMP, 20'h7FFFF, 1'b0, 32'd0},
		'{CAL_TYPICAL, KIND_TEMP, 20'h80000, 1'b0, 32'd0},
		// coefficient extremes, intermediates wrap
		'{CAL_MAX,     KIND_TEMP, 20'hFFFFF, 1'b0, 32'd0},
		'{CAL_MAX,     KIND_HUM,  20'h0FFFF, 1'b0, 32'd0},
		'{CAL_MAX,     KIND_TEMP, 20'h00000, 1'b0, 32'd0},
		'{CAL_MAX,     KIND_HUM,  20'h00000, 1'b0, 32'd0},
		'{CAL_MIN,     KIND_TEMP, 20'hFFFFF, 1'b0, 32'd0},
		'{CAL_MIN,     KIND_HUM,  20'hFFFFF, 1'b0, 32'd0},
		'{CAL_MIN,     KIND_TEMP, 20'h55555, 1'b0, 32'd0},
		'{CAL_MIN,     KIND_HUM,  20'hAAAAA, 1'b0, 32'd0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_reg_t   cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	thc_in_if  sample_ch();
	thc_out_if result_ch();

	temp_humidity_compensation uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Predictor copy of the coefficient registers and the stored fine temperature.
	logic [15:0] reg_t1 = '0, reg_t2 = '0, reg_t3 = '0, reg_h2 = '0;
	logic [7:0]  reg_h1 = '0, reg_h3 = '0, reg_h6 = '0;
	logic [31:0] reg_h45 = '0;
	logic [31:0] fine_temp = '0;

	reading_t pending_readings [$];   // results still owed by the block
	int       idle_pct = 0;            // chance of an idle burst, both sides
	int       errors = 0;
	int       cycles = 0;
	int       stall_left = 0;

	function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic void apply_cfg(input cfg_reg_t idx, input logic [31:0] v);
		case (idx)
			CFG_T1:  reg_t1 = v[15:0];
			CFG_T2:  reg_t2 = v[15:0];
			CFG_T3:  reg_t3 = v[15:0];
			CFG_H1:  reg_h1 = v[7:0];
			CFG_H2:  reg_h2 = v[15:0];
			CFG_H3:  reg_h3 = v[7:0];
			CFG_H45: reg_h45 = v;
			CFG_H6:  reg_h6 = v[7:0];
			default: ;
		endcase
	endfunction

	// 32-bit wrapping integer compensation. Temperature words update fine_temp.
	function automatic logic [31:0] compensate(input kind_t kind, input logic [19:0] raw);
		logic [31:0] r, t1, t2, t3, lin, dt;
		logic [31:0] h1, h2, h3, h4, h5, h6, x, p, q, s;
		if (kind == KIND_TEMP) begin
			r   = {12'd0, raw};
			t1  = {16'd0, reg_t1};
			t2  = {{16{reg_t2[15]}}, reg_t2};
			t3  = {{16{reg_t3[15]}}, reg_t3};
			lin = (r >> 3) - (t1 << 1);
			dt  = (r >> 4) - t1;
			fine_temp = sra(lin * t2, 11) + sra(sra(dt * dt, 12) * t3, 14);
			return sra(fine_temp * 32'd5 + RND_TEMP, 8);
		end
		r  = {16'd0, raw[15:0]};   // humidity ADC is 16 bits
		h1 = {24'd0, reg_h1};
		h2 = {{16{reg_h2[15]}}, reg_h2};
		h3 = {24'd0, reg_h3};
		h4 = {{16{reg_h45[15]}}, reg_h45[15:0]};
		h5 = {{16{reg_h45[31]}}, reg_h45[31:16]};
		h6 = {{24{reg_h6[7]}}, reg_h6};
		x  = fine_temp - HUM_X_OFFSET;
		p  = sra((r << 14) - (h4 << 20) - h5 * x + RND_P, 15);
		q  = sra(sra(x * h6, 10) * (sra(x * h3, 11) + OFS_Q2), 10) + OFS_Q;
		q  = sra(q * h2 + RND_Q, 14);
		x  = p * q;
		s  = sra(x, 15);
		x  = x - sra(sra(s * s, 7) * h1, 4);
		if (x[31]) begin
			x = '0;
		end else if (x > HUM_UPPER) begin
			x = HUM_UPPER;
		end
		return x >> 12;
	endfunction

	// Waits for the block to go idle, then writes all eight coefficient registers.
	task automatic write_calibration(input cal_style_t style);
		logic [31:0] cal_set [CFG_COUNT];
		case (style)
			CAL_TYPICAL: begin
				cal_set[CFG_T1]  = 32'd27504;
				cal_set[CFG_T2]  = 32'd26435;
				cal_set[CFG_T3]  = -32'sd1000;
				cal_set[CFG_H1]  = 32'd75;
				cal_set[CFG_H2]  = 32'd362;
				cal_set[CFG_H3]  = 32'd0;
				cal_set[CFG_H45] = {16'd50, 16'd313};
				cal_set[CFG_H6]  = 32'd30;
			end
			CAL_MAX: begin
				cal_set[CFG_T1]  = 32'h0000FFFF;
				cal_set[CFG_T2]  = 32'h00007FFF;
				cal_set[CFG_T3]  = 32'h00007FFF;
				cal_set[CFG_H1]  = 32'h000000FF;
				cal_set[CFG_H2]  = 32'h00007FFF;
				cal_set[CFG_H3]  = 32'h000000FF;
				cal_set[CFG_H45] = 32'h7FFF7FFF;
				cal_set[CFG_H6]  = 32'h0000007F;
			end
			CAL_MIN: begin
				cal_set[CFG_T1]  = 32'h00000000;
				cal_set[CFG_T2]  = 32'hFFFF8000;   // upper bits set, must be dropped
				cal_set[CFG_T3]  = 32'h00008000;
				cal_set[CFG_H1]  = 32'hFFFFFF00;
				cal_set[CFG_H2]  = 32'h00008000;
				cal_set[CFG_H3]  = 32'h00000000;
				cal_set[CFG_H45] = 32'h80008000;
				cal_set[CFG_H6]  = 32'hFFFFFF80;
			end
			CAL_NEAR: begin
				cal_set[CFG_T1]  = $urandom_range(29000, 26000);
				cal_set[CFG_T2]  = $urandom_range(27500, 25000);
				cal_set[CFG_T3]  = 32'($urandom_range(1050, 0)) - 32'd1000;
				cal_set[CFG_H1]  = $urandom_range(100, 0);
				cal_set[CFG_H2]  = $urandom_range(420, 300);
				cal_set[CFG_H3]  = $urandom_range(8, 0);
				cal_set[CFG_H45] = {16'($urandom_range(60, 0)), 16'($urandom_range(340, 280))};
				cal_set[CFG_H6]  = $urandom_range(35, 20);
			end
			default: begin
				for (int i = 0; i < CFG_COUNT; i++) begin
					cal_set[i] = $urandom();
				end
			end
		endcase
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
		for (int i = 0; i < CFG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_wdata <= cal_set[i];
			apply_cfg(cfg_reg_t'(i), cal_set[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Drives one sample word, waits for acceptance and books its expected result.
	// Valid stays high between back-to-back words.
	task automatic send_word(input kind_t kind, input logic [19:0] raw,
			input logic typed, input logic [31:0] value);
		logic [31:0] predicted;
		if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.req_type  <= kind;
		sample_ch.raw_value <= raw;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
		predicted = compensate(kind, raw);
		pending_readings.push_back(reading_t'{kind, typed ? value : predicted});
	endtask

	// Mostly plausible readings; the rest spans the whole 20-bit field.
	task automatic send_random_word();
		kind_t       kind;
		logic [19:0] raw;
		kind = kind_t'($urandom_range(1, 0));
		if ($urandom_range(9, 0) < 3) begin
			raw = 20'($urandom());
		end else if (kind == KIND_TEMP) begin
			raw = 20'($urandom_range(600000, 400000));
		end else begin
			raw = {4'($urandom()), 16'($urandom_range(45000, 20000))};
		end
		send_word(kind, raw, 1'b0, '0);
	endtask

	// Result side back-pressure: random stall bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(4, 0);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Result checker: every accepted result word against the oldest booking.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				errors++;
				if (errors <= PRINT_LIMIT)
					$display("%0t: unexpected result: expected none, got kind %0d value %0d",
						$time, result_ch.result_kind, result_ch.result_value);
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.result_kind !== want.kind) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display("%0t: result_kind: expected %0d, got %0d",
							$time, want.kind, result_ch.result_kind);
				end
				if (result_ch.result_value !== want.value) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display("%0t: result_value: expected %0d, got %0d",
							$time, $signed(want.value), result_ch.result_value);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int sent;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_T1;
		cfg_wdata           = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.req_type  = KIND_TEMP;
		sample_ch.raw_value = '0;
		result_ch.ready     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; a calibration change waits for the block to drain.
		idle_pct = 25;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cal != CAL_KEEP)
				write_calibration(directed_rows[i].cal);
			send_word(directed_rows[i].kind, directed_rows[i].raw,
				directed_rows[i].typed, directed_rows[i].value);
		end

		// Random phases: new coefficients and a new idling level each time.
		sent = 0;
		while (sent < RANDOM_WORDS - FINAL_WORDS) begin
			case ($urandom_range(9, 0))
				0:       write_calibration(CAL_RANDOM);
				1:       write_calibration(CAL_MAX);
				2:       write_calibration(CAL_MIN);
				3:       write_calibration(CAL_TYPICAL);
				default: write_calibration(CAL_NEAR);
			endcase
			case ($urandom_range(2, 0))
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				default: idle_pct = 40;
			endcase
			repeat ($urandom_range(120, 40)) begin
				if (sent < RANDOM_WORDS - FINAL_WORDS) begin
					send_random_word();
					sent++;
				end
			end
		end

		// Full-rate tail.
		idle_pct = 0;
		write_calibration(CAL_NEAR);
		repeat (FINAL_WORDS) send_random_word();

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/thc_pkg.sv
design/thc_if.sv
design/thc_datapath.sv
design/thc_ctrl.sv
design/temp_humidity_compensation.sv
design/thc_checker.sv
tb/temp_humidity_compensation_test.sv
